// ===== design/gahd_pkg.sv =====
// shared constants for the gas alarm hysteresis debounce block
`timescale 1ns / 1ps
`default_nettype none

package gahd_pkg;

    // register field widths
    localparam int unsigned THRESH_W   = 14;
    localparam int unsigned HYST_W     = 12;
    localparam int unsigned MARGIN_W   = 12;
    localparam int unsigned DEBOUNCE_W = 7;
    localparam int unsigned RELEASE_W  = 8;
    localparam int unsigned TICK_W     = 9;

    // result field widths
    localparam int unsigned LEVEL_W = 2;
    localparam int unsigned PPM_W   = 10;
    localparam int unsigned MV_W    = 12;
    localparam int unsigned COUNT_W = 8;
    localparam int unsigned PHASE_W = 10;

    // alarm level codes
    localparam logic [LEVEL_W-1:0] LEVEL_SAFE  = 2'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_WARN  = 2'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_ALARM = 2'd2;

    // apb map
    localparam int unsigned ADDR_W     = 5;
    localparam int unsigned DATA_W     = 32;
    localparam int unsigned REG_IDX_W  = 3;

    typedef logic [REG_IDX_W-1:0] t_reg_idx;

    localparam t_reg_idx REG_THRESHOLD = 3'd0;
    localparam t_reg_idx REG_HYST      = 3'd1;
    localparam t_reg_idx REG_MARGIN    = 3'd2;
    localparam t_reg_idx REG_DEBOUNCE  = 3'd3;
    localparam t_reg_idx REG_RELEASE   = 3'd4;
    localparam t_reg_idx REG_TICK      = 3'd5;

    // register reset values
    localparam logic [THRESH_W-1:0]   RST_THRESHOLD = 14'd1000;
    localparam logic [HYST_W-1:0]     RST_HYST      = 12'd200;
    localparam logic [MARGIN_W-1:0]   RST_MARGIN    = 12'd300;
    localparam logic [DEBOUNCE_W-1:0] RST_DEBOUNCE  = 7'd3;
    localparam logic [RELEASE_W-1:0]  RST_RELEASE   = 8'd9;
    localparam logic [TICK_W-1:0]     RST_TICK      = 9'd10;

    // conversion constants
    localparam longint unsigned FULL_SCALE_MV = 64'd3300;
    localparam logic [12:0] SMV_CUTOFF  = 13'd4950;
    localparam logic [12:0] SMV_BASE    = 13'd5000;
    // floor(v / 5) as (v * DIV5_MUL) >> DIV5_SHIFT, exact for v below 52428
    localparam logic [15:0] DIV5_MUL    = 16'd52429;
    localparam int unsigned DIV5_SHIFT  = 18;
    localparam int unsigned DIV5_PROD_W = 29;

    // phase constants in ms
    localparam logic [10:0] PHASE_WRAP = 11'd1000;
    localparam logic [PHASE_W-1:0] PHASE_HALF = 10'd500;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

endpackage

`default_nettype wire

// ===== design/gas_alarm_hysteresis_debounce.sv =====
// top level of the gas alarm with hysteresis and debounce
//
//  channel | direction | signals                              | beat
//  --------+-----------+--------------------------------------+-----------------------------
//  in      | to block  | i_valid, o_ready, i_filtered_adc,    | one sensor tick
//          |           | i_gas_pin                            |
//  out     | from block| o_valid, i_ready, o_alarm_level ...  | one result per tick
//  apb     | to block  | psel, penable, pwrite, paddr, pwdata,| one register write or read
//          |           | prdata, pready                       |
//
//  one beat accepted per cycle unless a stalled output fills all stages
//  stages: input register, millivolt register (scale multiply), result register
//  (ppm divide by five, level machine); the level machine steps as a tick enters the
//  result register
//  a stalled output holds all stages that are full; empty stages still fill
//  synchronous active-low reset restores the register defaults and the safe level
`timescale 1ns / 1ps
`default_nettype none

module gas_alarm_hysteresis_debounce #(
    parameter int unsigned ADC_BITS = 12
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output      logic                           o_ready,
    input  wire logic [ADC_BITS-1:0]            i_filtered_adc,
    input  wire logic                           i_gas_pin,
    output      logic                           o_valid,
    input  wire logic                           i_ready,
    output      logic [gahd_pkg::LEVEL_W-1:0]   o_alarm_level,
    output      logic [gahd_pkg::PPM_W-1:0]     o_gas_ppm,
    output      logic                           o_relay_on,
    output      logic                           o_red_led,
    output      logic                           o_green_led,
    output      logic                           o_buzzer_on,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [gahd_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [gahd_pkg::DATA_W-1:0]    pwdata,
    output      logic [gahd_pkg::DATA_W-1:0]    prdata,
    output      logic                           pready
);

    // millivolts = reading * 3300 / (2^N - 1), done as a multiply by a rounded-up
    // reciprocal scaled by 2^(2N), exact over the whole reading range
    localparam longint unsigned ADC_FULL = (64'd1 << ADC_BITS) - 64'd1;
    localparam longint unsigned MV_COEF_VAL =
        ((gahd_pkg::FULL_SCALE_MV << (2 * ADC_BITS)) + ADC_FULL - 64'd1) / ADC_FULL;
    localparam int unsigned MV_COEF_W = ADC_BITS + 12;
    localparam int unsigned MV_PROD_W = ADC_BITS + MV_COEF_W;
    localparam logic [MV_COEF_W-1:0] MV_COEF = MV_COEF_W'(MV_COEF_VAL);

    typedef enum logic [gahd_pkg::LEVEL_W-1:0] {
        ST_SAFE  = gahd_pkg::LEVEL_SAFE,
        ST_WARN  = gahd_pkg::LEVEL_WARN,
        ST_ALARM = gahd_pkg::LEVEL_ALARM
    } t_level;

    // configuration registers
    logic [gahd_pkg::THRESH_W-1:0]   r_threshold;
    logic [gahd_pkg::HYST_W-1:0]     r_hyst;
    logic [gahd_pkg::MARGIN_W-1:0]   r_margin;
    logic [gahd_pkg::DEBOUNCE_W-1:0] r_debounce;
    logic [gahd_pkg::RELEASE_W-1:0]  r_release;
    logic [gahd_pkg::TICK_W-1:0]     r_tick_ms;

    logic                     cfg_write;
    gahd_pkg::t_reg_idx       cfg_idx;

    // pipeline
    logic                     r_a_valid;
    logic [ADC_BITS-1:0]      r_a_adc;
    logic                     r_a_pin;
    logic                     r_b_valid;
    logic [gahd_pkg::MV_W-1:0] r_b_mv;
    logic                     r_b_pin;
    logic                     r_out_valid;

    logic                     out_adv;
    logic                     b_adv;
    logic                     a_adv;
    logic                     b_fire;

    logic [MV_PROD_W-1:0]     mv_prod;
    logic [gahd_pkg::MV_W-1:0] mv;

    logic [12:0]              smv;
    logic                     ppm_zero;
    logic [12:0]              ppm_num;
    logic [gahd_pkg::DIV5_PROD_W-1:0] ppm_prod;
    logic [gahd_pkg::PPM_W-1:0] ppm;

    logic [14:0]              entry_lvl;
    logic [14:0]              escalate_lvl;
    logic [gahd_pkg::THRESH_W-1:0] release_lvl;
    logic                     ppm_ge_entry;
    logic                     ppm_ge_escalate;
    logic                     ppm_low;

    // level machine
    t_level                   r_level;
    t_level                   n_level;
    logic [gahd_pkg::COUNT_W-1:0] r_count;
    logic [gahd_pkg::COUNT_W-1:0] n_count;
    logic [gahd_pkg::COUNT_W-1:0] count_inc;
    logic [gahd_pkg::PHASE_W-1:0] r_phase;
    logic [gahd_pkg::PHASE_W-1:0] n_phase;
    logic [10:0]              phase_sum;

    logic [gahd_pkg::LEVEL_W-1:0] r_out_level;
    logic [gahd_pkg::PPM_W-1:0]   r_out_ppm;
    logic                     r_out_relay;
    logic                     r_out_red;
    logic                     r_out_green;
    logic                     r_out_buzzer;

    // apb
    assign pready    = 1'b1;
    assign cfg_idx   = paddr[gahd_pkg::ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= gahd_pkg::RST_THRESHOLD;
            r_hyst      <= gahd_pkg::RST_HYST;
            r_margin    <= gahd_pkg::RST_MARGIN;
            r_debounce  <= gahd_pkg::RST_DEBOUNCE;
            r_release   <= gahd_pkg::RST_RELEASE;
            r_tick_ms   <= gahd_pkg::RST_TICK;
        end else if (cfg_write) begin
            unique case (cfg_idx)
                gahd_pkg::REG_THRESHOLD: begin
                    r_threshold <= pwdata[gahd_pkg::THRESH_W-1:0];
                end
                gahd_pkg::REG_HYST: begin
                    r_hyst <= pwdata[gahd_pkg::HYST_W-1:0];
                end
                gahd_pkg::REG_MARGIN: begin
                    r_margin <= pwdata[gahd_pkg::MARGIN_W-1:0];
                end
                gahd_pkg::REG_DEBOUNCE: begin
                    r_debounce <= pwdata[gahd_pkg::DEBOUNCE_W-1:0];
                end
                gahd_pkg::REG_RELEASE: begin
                    r_release <= pwdata[gahd_pkg::RELEASE_W-1:0];
                end
                gahd_pkg::REG_TICK: begin
                    r_tick_ms <= pwdata[gahd_pkg::TICK_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            gahd_pkg::REG_THRESHOLD: prdata = gahd_pkg::DATA_W'(r_threshold);
            gahd_pkg::REG_HYST:      prdata = gahd_pkg::DATA_W'(r_hyst);
            gahd_pkg::REG_MARGIN:    prdata = gahd_pkg::DATA_W'(r_margin);
            gahd_pkg::REG_DEBOUNCE:  prdata = gahd_pkg::DATA_W'(r_debounce);
            gahd_pkg::REG_RELEASE:   prdata = gahd_pkg::DATA_W'(r_release);
            gahd_pkg::REG_TICK:      prdata = gahd_pkg::DATA_W'(r_tick_ms);
            default:                 prdata = '0;
        endcase
    end

    // flow control
    assign out_adv = !r_out_valid || i_ready;
    assign b_adv   = !r_b_valid || out_adv;
    assign a_adv   = !r_a_valid || b_adv;
    assign b_fire  = r_b_valid && out_adv;
    assign o_ready = a_adv;

    // stage a: input register, stage b: millivolts
    assign mv_prod = MV_PROD_W'(r_a_adc) * MV_PROD_W'(MV_COEF);
    assign mv      = mv_prod[MV_PROD_W-1 -: gahd_pkg::MV_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (a_adv) begin
                r_a_valid <= i_valid;
            end
            if (b_adv) begin
                r_b_valid <= r_a_valid;
            end
        end
        if (a_adv && i_valid) begin
            r_a_adc <= i_filtered_adc;
            r_a_pin <= i_gas_pin;
        end
        if (b_adv && r_a_valid) begin
            r_b_mv  <= mv;
            r_b_pin <= r_a_pin;
        end
    end

    // ppm and level compares
    assign smv      = {r_b_mv, 1'b0};
    assign ppm_zero = smv >= gahd_pkg::SMV_CUTOFF;
    assign ppm_num  = gahd_pkg::SMV_BASE - smv;
    assign ppm_prod = gahd_pkg::DIV5_PROD_W'(ppm_num)
                    * gahd_pkg::DIV5_PROD_W'(gahd_pkg::DIV5_MUL);
    assign ppm      = ppm_zero ? '0
                    : ppm_prod[gahd_pkg::DIV5_SHIFT +: gahd_pkg::PPM_W];

    assign entry_lvl       = 15'(r_threshold) + 15'(r_hyst);
    assign escalate_lvl    = entry_lvl + 15'(r_margin);
    assign release_lvl     = r_threshold - gahd_pkg::THRESH_W'(r_hyst);
    assign ppm_ge_entry    = 15'(ppm) >= entry_lvl;
    assign ppm_ge_escalate = 15'(ppm) >= escalate_lvl;
    assign ppm_low         = (r_threshold >= gahd_pkg::THRESH_W'(r_hyst))
                          && (gahd_pkg::THRESH_W'(ppm) < release_lvl);

    always_comb begin
        phase_sum = 11'(r_phase) + 11'(r_tick_ms);
        if (phase_sum >= gahd_pkg::PHASE_WRAP) begin
            n_phase = gahd_pkg::PHASE_W'(phase_sum - gahd_pkg::PHASE_WRAP);
        end else begin
            n_phase = gahd_pkg::PHASE_W'(phase_sum);
        end
        count_inc = (r_count == gahd_pkg::COUNT_MAX) ? r_count : r_count + 8'd1;
        n_level   = r_level;
        n_count   = '0;
        unique case (r_level)
            ST_SAFE: begin
                if (ppm_ge_entry || r_b_pin) begin
                    if (count_inc >= 8'(r_debounce)) begin
                        n_level = ST_WARN;
                    end else begin
                        n_count = count_inc;
                    end
                end
            end
            ST_WARN: begin
                if (ppm_ge_escalate) begin
                    if (count_inc >= 8'(r_debounce)) begin
                        n_level = ST_ALARM;
                    end else begin
                        n_count = count_inc;
                    end
                end else if (ppm_low) begin
                    if (count_inc >= 8'(r_debounce)) begin
                        n_level = ST_SAFE;
                    end else begin
                        n_count = count_inc;
                    end
                end
            end
            ST_ALARM: begin
                if (ppm_low) begin
                    if (count_inc >= r_release) begin
                        n_level = ST_SAFE;
                    end else begin
                        n_count = count_inc;
                    end
                end
            end
            default: begin
                n_level = ST_SAFE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level     <= ST_SAFE;
            r_count     <= '0;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_adv) begin
                r_out_valid <= r_b_valid;
            end
            if (b_fire) begin
                r_level      <= n_level;
                r_count      <= n_count;
                r_phase      <= n_phase;
                r_out_level  <= n_level;
                r_out_ppm    <= ppm;
                r_out_relay  <= (n_level == ST_ALARM);
                r_out_red    <= (n_level != ST_SAFE);
                r_out_green  <= (n_level == ST_SAFE);
                r_out_buzzer <= (n_level == ST_ALARM)
                             || ((n_level == ST_WARN) && (n_phase >= gahd_pkg::PHASE_HALF));
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_alarm_level = r_out_level;
    assign o_gas_ppm     = r_out_ppm;
    assign o_relay_on    = r_out_relay;
    assign o_red_led     = r_out_red;
    assign o_green_led   = r_out_green;
    assign o_buzzer_on   = r_out_buzzer;

endmodule

`default_nettype wire

// ===== design/gahd_checker.sv =====
// port-level checks for the gas alarm block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module gahd_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         o_valid,
    input wire logic                         i_ready,
    input wire logic [gahd_pkg::LEVEL_W-1:0] o_alarm_level,
    input wire logic [gahd_pkg::PPM_W-1:0]   o_gas_ppm,
    input wire logic                         o_relay_on,
    input wire logic                         o_red_led,
    input wire logic                         o_green_led,
    input wire logic                         o_buzzer_on
);

    // nothing comes out in the cycle after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // a stalled beat holds its level and ppm
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_alarm_level) && $stable(o_gas_ppm))
        else $error("stalled result changed");

    // lamps agree with the level
    a_lamps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_green_led == (o_alarm_level == gahd_pkg::LEVEL_SAFE))
                 && (o_red_led == !o_green_led)
                 && (o_relay_on == (o_alarm_level == gahd_pkg::LEVEL_ALARM)))
        else $error("lamp drives disagree with level");

    // buzzer is steady in alarm and silent in safe
    a_buzzer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_relay_on == (o_relay_on && o_buzzer_on))
                 && !(o_green_led && o_buzzer_on))
        else $error("buzzer disagrees with level");

    // level and ppm stay in range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_alarm_level <= gahd_pkg::LEVEL_ALARM) && (o_gas_ppm <= 10'd1000))
        else $error("result out of range");

endmodule

bind gas_alarm_hysteresis_debounce gahd_checker u_gahd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_alarm_level (o_alarm_level),
    .o_gas_ppm     (o_gas_ppm),
    .o_relay_on    (o_relay_on),
    .o_red_led     (o_red_led),
    .o_green_led   (o_green_led),
    .o_buzzer_on   (o_buzzer_on)
);

`default_nettype wire
